[hdl/tca_pkg.sv]
// ============================================================================
// Temperature calibrate and average: shared package
// Field widths, calibration and scaling constants, register indexes and the
// sequencer state type.
// ============================================================================
package tca_pkg;

  // Field widths.
  localparam int CAL_W  = 12;  // converter readings and calibration points
  localparam int DEG_W  = 10;  // whole degrees Celsius held in the ring
  localparam int CELS_W = 14;  // tenths of a degree Celsius
  localparam int FAHR_W = 15;  // tenths of a degree Fahrenheit
  localparam int USED_W = 4;   // sample count on the result channel

  // Signed width of (raw - low) * 55.
  localparam int CAL_NUM_W = 19;

  // Default averaging window.
  localparam int WINDOW_LEN_DEF = 10;

  // Calibration: 30 C and 85 C are the two reference points.
  localparam int CAL_BASE_DEG = 30;
  localparam int CAL_SPAN_DEG = 85 - 30;
  localparam int DEG_MIN      = -256;
  localparam int DEG_MAX      = 511;

  // Scaling to tenths: C10 = 10 * mean, F10 = 18 * mean + 320.
  localparam int C_SCALE  = 10;
  localparam int F_SCALE  = 18;
  localparam int F_OFFSET = 320;

  // Calibration register reset values.
  localparam logic [CAL_W-1:0] CAL_LOW_RESET  = 12'h000;
  localparam logic [CAL_W-1:0] CAL_HIGH_RESET = 12'hFFF;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_LOW  = 1'b0,
    CFG_CAL_HIGH = 1'b1
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CAL_GO,
    S_CAL_WAIT,
    S_WRITE,
    S_SUM,
    S_MUL,
    S_C_GO,
    S_C_WAIT,
    S_F_GO,
    S_F_WAIT,
    S_DONE
  } state_e;

endpackage

[hdl/tca_in_if.sv]
// ============================================================================
// Temperature calibrate and average: sample channel
// Valid/ready channel carrying one converter reading and the hold flag.
// ============================================================================
interface tca_in_if;
  logic                       valid;
  logic                       ready;
  logic [tca_pkg::CAL_W-1:0]  raw_sample;
  logic                       hold;

  modport source (output valid, output raw_sample, output hold, input ready);
  modport sink   (input valid, input raw_sample, input hold, output ready);
endinterface

[hdl/tca_out_if.sv]
// ============================================================================
// Temperature calibrate and average: result channel
// Valid/ready channel carrying the averaged temperature in both scales.
// ============================================================================
interface tca_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tca_pkg::CELS_W-1:0]  avg_celsius_tenths;
  logic signed [tca_pkg::FAHR_W-1:0]  avg_fahrenheit_tenths;
  logic        [tca_pkg::USED_W-1:0]  samples_used;
  logic                               cal_error;

  modport source (output valid, output avg_celsius_tenths, output avg_fahrenheit_tenths,
                  output samples_used, output cal_error, input ready);
  modport sink   (input valid, input avg_celsius_tenths, input avg_fahrenheit_tenths,
                  input samples_used, input cal_error, output ready);
endinterface

[hdl/tca_cfg_if.sv]
// ============================================================================
// Temperature calibrate and average: configuration channel
// Valid/ready write channel carrying a register index and write data.
// ============================================================================
interface tca_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tca_pkg::CFG_IDX_W-1:0]  index;
  logic [tca_pkg::CAL_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/temperature_calibrate_average_top.sv]
// ============================================================================
// Temperature calibrate and average: top level
// Two-point calibration of sensor readings and a moving average over a ring
// of calibrated samples, reported in tenths of degrees Celsius and Fahrenheit.
// ============================================================================
// Usage. Calibration points are written on cfg_i (index 0 is the reading at
// 30 C, index 1 the reading at 85 C); cfg_i is always ready and should only
// be written while the block is idle. Each beat on sample_i carries one raw
// reading; each accepted beat produces exactly one beat on result_o with the
// mean of the last samples_used calibrated samples.
// Items are taken one at a time and run through a sequencer that shares a
// single bit-serial divider for the calibration quotient and for the two
// mean quotients; the divider is 20 bits wide for the default window. The
// result becomes valid on result_o in the same cycle that sample_i is ready
// again. A bad calibration skips the first division. The summing pass reads
// one ring entry per cycle from the sample memory.
// A finished result sits in an output register, so sample_i is ready again as
// soon as the sequencer returns to idle; if result_o is stalled, the next
// item is worked on and then waits in its final state until the output
// register is free. Reset empties the ring (no sample counted), restores the
// default calibration points and drops any pending result.
// ============================================================================
module temperature_calibrate_average_top #(
  parameter int WINDOW_LEN = tca_pkg::WINDOW_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tca_cfg_if.sink   cfg_i,
  tca_in_if.sink    sample_i,
  tca_out_if.source result_o
);

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W = tca_pkg::DEG_W + $clog2(WINDOW_LEN);
  localparam int DVD_W = (SUM_W + 6 > tca_pkg::CAL_NUM_W) ? SUM_W + 6 : tca_pkg::CAL_NUM_W;
  localparam int DSR_W = tca_pkg::CAL_W;
  localparam int DEG_W = tca_pkg::DEG_W;

  localparam logic signed [DVD_W-1:0] SPAN_K   = DVD_W'(tca_pkg::CAL_SPAN_DEG);
  localparam logic signed [DVD_W-1:0] C_MUL_K  = DVD_W'(tca_pkg::C_SCALE);
  localparam logic signed [DVD_W-1:0] F_MUL_K  = DVD_W'(tca_pkg::F_SCALE);
  localparam logic signed [DVD_W-1:0] F_OFS_K  = DVD_W'(tca_pkg::F_OFFSET);
  localparam logic signed [DVD_W:0]   BASE_K   = (DVD_W + 1)'(tca_pkg::CAL_BASE_DEG);
  localparam logic signed [DVD_W:0]   DMIN_K   = (DVD_W + 1)'(tca_pkg::DEG_MIN);
  localparam logic signed [DVD_W:0]   DMAX_K   = (DVD_W + 1)'(tca_pkg::DEG_MAX);
  localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(WINDOW_LEN - 1);
  localparam logic [CNT_W-1:0]        FULL_CNT = CNT_W'(WINDOW_LEN);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  tca_pkg::state_e state_q, state_d;

  logic [tca_pkg::CAL_W-1:0] cal_low_q, cal_high_q;

  // Per-item registers captured when a sample is accepted.
  logic signed [DVD_W-1:0] num_q;
  logic [DSR_W-1:0]        diff_q;
  logic                    err_q;
  logic                    hold_q;
  logic [CNT_W-1:0]        used_q;

  // Ring bookkeeping.
  logic [IDX_W-1:0] slot_q;
  logic [CNT_W-1:0] filled_q;

  // Summing pass.
  logic [IDX_W-1:0]        rd_ptr_q;
  logic [CNT_W-1:0]        rd_left_q;
  logic                    rd_vld_q;
  logic signed [SUM_W-1:0] sum_q;

  // Mean dividends and division results.
  logic signed [DVD_W-1:0]          dvd_c_q, dvd_f_q;
  logic                             div_neg_q;
  logic signed [DVD_W:0]            res_q;
  logic signed [tca_pkg::CELS_W-1:0] c10_q;

  // Output register.
  logic                               out_vld_q;
  logic signed [tca_pkg::CELS_W-1:0]  out_c_q;
  logic signed [tca_pkg::FAHR_W-1:0]  out_f_q;
  logic        [tca_pkg::USED_W-1:0]  out_used_q;
  logic                               out_err_q;

  // Sequencer outputs.
  logic in_ready;
  logic ram_wr_en;
  logic ram_rd_en;
  logic div_start;
  logic out_load;

  logic                    in_acc;
  logic                    cal_bad;
  logic signed [DVD_W-1:0] raw_ext, low_ext;
  logic signed [DVD_W-1:0] div_src;
  logic [DVD_W-1:0]        div_mag;
  logic [DSR_W-1:0]        div_dsr;
  logic                    div_done;
  logic [DVD_W-1:0]        div_quot;
  logic signed [DVD_W:0]   quot_signed;
  logic signed [DVD_W:0]   deg_full;
  logic signed [DEG_W-1:0] deg;
  logic [DEG_W-1:0]        ram_rd_data;
  logic signed [DVD_W-1:0] sum_ext, used_ext;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_low_q  <= tca_pkg::CAL_LOW_RESET;
      cal_high_q <= tca_pkg::CAL_HIGH_RESET;
    end else if (cfg_i.valid) begin
      case (tca_pkg::cfg_idx_e'(cfg_i.index))
        tca_pkg::CFG_CAL_LOW:  cal_low_q  <= cfg_i.data;
        tca_pkg::CFG_CAL_HIGH: cal_high_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_acc  = sample_i.valid && in_ready;
  assign cal_bad = (cal_high_q <= cal_low_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      tca_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = cal_bad ? tca_pkg::S_WRITE : tca_pkg::S_CAL_GO;
        end
      end
      tca_pkg::S_CAL_GO:   state_d = tca_pkg::S_CAL_WAIT;
      tca_pkg::S_CAL_WAIT: begin
        if (div_done) begin
          state_d = tca_pkg::S_WRITE;
        end
      end
      tca_pkg::S_WRITE:    state_d = tca_pkg::S_SUM;
      tca_pkg::S_SUM: begin
        if ((rd_left_q == '0) && !rd_vld_q) begin
          state_d = tca_pkg::S_MUL;
        end
      end
      tca_pkg::S_MUL:      state_d = tca_pkg::S_C_GO;
      tca_pkg::S_C_GO:     state_d = tca_pkg::S_C_WAIT;
      tca_pkg::S_C_WAIT: begin
        if (div_done) begin
          state_d = tca_pkg::S_F_GO;
        end
      end
      tca_pkg::S_F_GO:     state_d = tca_pkg::S_F_WAIT;
      tca_pkg::S_F_WAIT: begin
        if (div_done) begin
          state_d = tca_pkg::S_DONE;
        end
      end
      tca_pkg::S_DONE: begin
        if (out_load) begin
          state_d = tca_pkg::S_IDLE;
        end
      end
      default:             state_d = tca_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_wr_en = 1'b0;
    ram_rd_en = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      tca_pkg::S_IDLE:  in_ready  = 1'b1;
      tca_pkg::S_WRITE: ram_wr_en = 1'b1;
      tca_pkg::S_SUM:   ram_rd_en = (rd_left_q != '0);
      tca_pkg::S_CAL_GO, tca_pkg::S_C_GO, tca_pkg::S_F_GO: div_start = 1'b1;
      tca_pkg::S_DONE:  out_load  = !out_vld_q || result_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tca_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign sample_i.ready = in_ready;

  // --------------------------------------------------------------------------
  // Item capture: calibration numerator, divisor and sample count
  // --------------------------------------------------------------------------
  assign raw_ext = $signed({{(DVD_W - tca_pkg::CAL_W){1'b0}}, sample_i.raw_sample});
  assign low_ext = $signed({{(DVD_W - tca_pkg::CAL_W){1'b0}}, cal_low_q});

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      num_q  <= (raw_ext - low_ext) * SPAN_K;
      diff_q <= cal_high_q - cal_low_q;
      err_q  <= cal_bad;
      hold_q <= sample_i.hold;
      used_q <= (filled_q == FULL_CNT) ? filled_q : filled_q + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Shared divider. Both divisors are positive, so the quotient takes the
  // sign of the dividend and truncation toward zero falls out of dividing
  // magnitudes.
  // --------------------------------------------------------------------------
  always_comb begin
    case (state_q)
      tca_pkg::S_CAL_GO: begin
        div_src = num_q;
        div_dsr = diff_q;
      end
      tca_pkg::S_C_GO: begin
        div_src = dvd_c_q;
        div_dsr = DSR_W'(used_q);
      end
      default: begin
        div_src = dvd_f_q;
        div_dsr = DSR_W'(used_q);
      end
    endcase
    div_mag = div_src[DVD_W-1] ? DVD_W'(-div_src) : DVD_W'(div_src);
  end

  tca_div #(
    .DVD_W (DVD_W),
    .DSR_W (DSR_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_mag),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign quot_signed = div_neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_neg_q <= div_src[DVD_W-1];
    end
    if (div_done) begin
      res_q <= quot_signed;
    end
    if (state_q == tca_pkg::S_F_GO) begin
      c10_q <= res_q[tca_pkg::CELS_W-1:0];
    end
  end

  // Calibrated degrees: quotient plus the 30 C base, saturated to the ring's
  // range. A bad calibration stands in as 30 C.
  always_comb begin
    deg_full = res_q + BASE_K;
    if (err_q) begin
      deg = DEG_W'(tca_pkg::CAL_BASE_DEG);
    end else if (deg_full < DMIN_K) begin
      deg = DEG_W'(tca_pkg::DEG_MIN);
    end else if (deg_full > DMAX_K) begin
      deg = DEG_W'(tca_pkg::DEG_MAX);
    end else begin
      deg = deg_full[DEG_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sample ring and summing pass. The new sample goes straight into the sum
  // while it is written; the older entries are read back one per cycle,
  // walking backwards from the slot before it. Those reads never touch the
  // slot being written, and one item finishes before the next begins, so no
  // forwarding is needed.
  // --------------------------------------------------------------------------
  tca_ram #(
    .WIDTH (DEG_W),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (slot_q),
    .wr_data_i (deg),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (rd_ptr_q),
    .rd_data_o (ram_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_left_q <= '0;
    end else if (state_q == tca_pkg::S_WRITE) begin
      rd_vld_q  <= 1'b0;
      rd_left_q <= used_q - 1'b1;
    end else begin
      rd_vld_q <= ram_rd_en;
      if (ram_rd_en) begin
        rd_left_q <= rd_left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tca_pkg::S_WRITE) begin
      rd_ptr_q <= (slot_q == '0) ? LAST_IDX : slot_q - 1'b1;
      sum_q    <= $signed({{(SUM_W - DEG_W){deg[DEG_W-1]}}, deg});
    end else begin
      if (ram_rd_en) begin
        rd_ptr_q <= (rd_ptr_q == '0) ? LAST_IDX : rd_ptr_q - 1'b1;
      end
      if (rd_vld_q) begin
        sum_q <= sum_q + $signed({{(SUM_W - DEG_W){ram_rd_data[DEG_W-1]}}, ram_rd_data});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scaling: 10 * sum for Celsius tenths, 18 * sum + 320 * n for Fahrenheit
  // tenths; both are then divided by n.
  // --------------------------------------------------------------------------
  assign sum_ext  = $signed({{(DVD_W - SUM_W){sum_q[SUM_W-1]}}, sum_q});
  assign used_ext = $signed({{(DVD_W - CNT_W){1'b0}}, used_q});

  always_ff @(posedge clk_i) begin
    if (state_q == tca_pkg::S_MUL) begin
      dvd_c_q <= sum_ext * C_MUL_K;
      dvd_f_q <= sum_ext * F_MUL_K + used_ext * F_OFS_K;
    end
  end

  // --------------------------------------------------------------------------
  // Ring pointers advance when the result is handed to the output register,
  // unless the item asked to hold its slot.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      filled_q <= '0;
    end else if (out_load && !hold_q) begin
      slot_q <= (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
      if (filled_q != FULL_CNT) begin
        filled_q <= filled_q + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_c_q    <= c10_q;
      out_f_q    <= res_q[tca_pkg::FAHR_W-1:0];
      out_used_q <= tca_pkg::USED_W'(used_q);
      out_err_q  <= err_q;
    end
  end

  assign result_o.valid                 = out_vld_q;
  assign result_o.avg_celsius_tenths    = out_c_q;
  assign result_o.avg_fahrenheit_tenths = out_f_q;
  assign result_o.samples_used          = out_used_q;
  assign result_o.cal_error             = out_err_q;

`ifndef SYNTHESIS
  // The backward walk must never read the slot that this item writes.
  a_rd_not_wr_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_rd_en |-> (rd_ptr_q != slot_q))
    else $error("ring read hits the slot being written");

  // The fill count and write slot stay inside the window.
  a_ring_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filled_q <= FULL_CNT) && (slot_q <= LAST_IDX))
    else $error("ring pointer out of range");

  // Once summing ends, the sum lies within n times the saturated range.
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tca_pkg::S_MUL) |->
      ((sum_q <= $signed({1'b0, used_q}) * tca_pkg::DEG_MAX) &&
       (sum_q >= $signed({1'b0, used_q}) * tca_pkg::DEG_MIN)))
    else $error("window sum out of range");

  // Averaging always covers at least the new sample and never more than the
  // entries written so far.
  a_used_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tca_pkg::S_WRITE) |->
      ((used_q != '0) && (used_q <= FULL_CNT) && (used_q <= filled_q + 1'b1)))
    else $error("sample count out of range");
`endif

endmodule

[hdl/tca_ram.sv]
// ============================================================================
// Temperature calibrate and average: generic RAM
// One write port and one read port, read data registered.
// ============================================================================
module tca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/tca_div.sv]
// ============================================================================
// Temperature calibrate and average: iterative divider
// Unsigned restoring divider producing one quotient bit per cycle.
// ============================================================================
module tca_div #(
  parameter int DVD_W = 20,
  parameter int DSR_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] work_q;
  logic [DSR_W-1:0] rem_q;
  logic [DSR_W-1:0] dsr_q;

  logic [DSR_W:0]   rem_sh;
  logic [DSR_W+1:0] trial;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    rem_sh = {rem_q, work_q[DVD_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dsr_q};
    fits   = ~trial[DSR_W+1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      work_q <= {work_q[DVD_W-2:0], fits};
      rem_q  <= fits ? trial[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = work_q;

endmodule
